// ===== design/dtpm_pkg.sv =====
// Shared types, codes and widths for the door travel plant model.
`default_nettype none

package dtpm_pkg;

    localparam int ELAPSED_W   = 16;
    localparam int POS_W       = 7;
    localparam int TRAVEL_W    = 20;
    localparam int THR_W       = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int PROD_W      = ELAPSED_W + POS_W;

    localparam int FULL_TRAVEL_DEF = 100;

    localparam logic [TRAVEL_W-1:0] TRAVEL_RST = TRAVEL_W'(10000);
    localparam logic [THR_W-1:0]    THR_RST    = THR_W'(5);

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRAVEL_TIME = 2'd0,
        REG_SIM_ENABLE  = 2'd1,
        REG_STUCK_MODE  = 2'd2,
        REG_HALL_THR    = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        DOOR_CLOSED  = 3'd0,
        DOOR_OPENING = 3'd1,
        DOOR_OPEN    = 3'd2,
        DOOR_CLOSING = 3'd3,
        DOOR_STOPPED = 3'd4
    } door_status_t;

    typedef enum logic [1:0] {
        DIR_STOP  = 2'd0,
        DIR_OPEN  = 2'd1,
        DIR_CLOSE = 2'd2,
        DIR_BRAKE = 2'd3
    } dir_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_DIV,
        FSM_COMMIT
    } fsm_t;

    // divider status towards the sequencer
    typedef struct packed {
        logic busy;
        logic last;
    } dtpm_div_stat_t;

    function automatic dir_t decode_dir(input logic p, input logic n);
        dir_t d;
        d = DIR_STOP;
        if (p && !n)
            d = DIR_OPEN;
        else if (!p && n)
            d = DIR_CLOSE;
        else if (p && n)
            d = DIR_BRAKE;
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== design/door_travel_plant_model_top.sv =====
// Door travel plant model: tick in, door position, state and hall levels out.
// Each accepted tick word is divided by the bit-serial divider (23 quotient bits), then
//   committed to the door state and the output word; no new tick word is accepted until
//   then, and a waiting result word does not block the next accept, only its commit.
// Reset (rst_n, asynchronous, active low): door closed at 0, registers to their defaults
//   (travel 10000 ms, simulation on, not stuck, hall margin 5).
`default_nettype none

module door_travel_plant_model_top #(
    parameter int FULL_TRAVEL = dtpm_pkg::FULL_TRAVEL_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [dtpm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dtpm_pkg::TRAVEL_W-1:0]   cfg_data,
    // tick words in
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [dtpm_pkg::ELAPSED_W-1:0]  elapsed_ms,
    input  wire logic                            motor_pos,
    input  wire logic                            motor_neg,
    // result words out
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [dtpm_pkg::POS_W-1:0]           door_pct,
    output logic [2:0]                           door_status,
    output logic [1:0]                           drive_dir,
    output logic                                 hall_open,
    output logic                                 hall_close
);

    localparam int POS_W  = dtpm_pkg::POS_W;
    localparam int PROD_W = dtpm_pkg::PROD_W;
    localparam int TRV_W  = dtpm_pkg::TRAVEL_W;
    localparam int THR_W  = dtpm_pkg::THR_W;

    localparam logic [POS_W-1:0] FT_POS = POS_W'(FULL_TRAVEL);

    // configuration registers
    logic [TRV_W-1:0] travel_reg;
    logic             sim_en_reg;
    logic             stuck_reg;
    logic [THR_W-1:0] thr_reg;

    // door state
    logic [POS_W-1:0]       position_reg, position_next;
    dtpm_pkg::door_status_t state_reg, state_next;

    // sequencer
    dtpm_pkg::fsm_t fsm_reg, fsm_next;
    dtpm_pkg::dir_t dir_reg;
    logic           div_start;
    logic           commit;

    // output register
    logic                   out_valid_reg;
    logic [POS_W-1:0]       out_pos_reg;
    dtpm_pkg::door_status_t out_state_reg;
    dtpm_pkg::dir_t         out_dir_reg;
    logic                   out_hopen_reg;
    logic                   out_hclose_reg;

    // divider
    dtpm_pkg::dtpm_div_stat_t div_stat;
    logic [PROD_W-1:0]        quot;
    logic [PROD_W-1:0]        product;
    logic [TRV_W-1:0]         divisor;

    logic             out_free;
    logic [POS_W-1:0] room;
    logic             move_open;
    logic             move_close;
    logic             old_at_open;
    logic             old_at_close;
    logic             new_at_open;
    logic             new_at_close;

    // ---------------------------------------------------------------- config
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            travel_reg <= dtpm_pkg::TRAVEL_RST;
            sim_en_reg <= 1'b1;
            stuck_reg  <= 1'b0;
            thr_reg    <= dtpm_pkg::THR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (dtpm_pkg::cfg_idx_t'(cfg_index))
                dtpm_pkg::REG_TRAVEL_TIME: travel_reg <= cfg_data;
                dtpm_pkg::REG_SIM_ENABLE:  sim_en_reg <= cfg_data[0];
                dtpm_pkg::REG_STUCK_MODE:  stuck_reg  <= cfg_data[0];
                dtpm_pkg::REG_HALL_THR:    thr_reg    <= cfg_data[THR_W-1:0];
                default:                   ;
            endcase
        end
    end

    // ---------------------------------------------------------------- divider
    // Delta is floor(elapsed * full travel / travel time); a zero travel time acts as 1.
    assign product = PROD_W'(elapsed_ms) * PROD_W'(FULL_TRAVEL);
    assign divisor = (travel_reg == '0) ? TRV_W'(1) : travel_reg;

    dtpm_div #(
        .DIVIDEND_W (PROD_W),
        .DIVISOR_W  (TRV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (divisor),
        .stat     (div_stat),
        .quotient (quot)
    );

    // ---------------------------------------------------------------- sequencer
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        fsm_next = fsm_reg;
        unique case (fsm_reg)
            dtpm_pkg::FSM_IDLE:
                if (in_valid)
                    fsm_next = dtpm_pkg::FSM_DIV;
            dtpm_pkg::FSM_DIV:
                if (div_stat.last)
                    fsm_next = dtpm_pkg::FSM_COMMIT;
            dtpm_pkg::FSM_COMMIT:
                if (out_free)
                    fsm_next = dtpm_pkg::FSM_IDLE;
            default:
                fsm_next = dtpm_pkg::FSM_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        div_start = 1'b0;
        commit    = 1'b0;
        unique case (fsm_reg)
            dtpm_pkg::FSM_IDLE:
            begin
                in_stall  = 1'b0;
                div_start = in_valid;
            end
            dtpm_pkg::FSM_DIV:
                ;
            dtpm_pkg::FSM_COMMIT:
                commit = out_free;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fsm_reg <= dtpm_pkg::FSM_IDLE;
        else
            fsm_reg <= fsm_next;
    end

    // drive lines held for the commit
    always_ff @(posedge clk)
    begin
        if (div_start)
            dir_reg <= dtpm_pkg::decode_dir(motor_pos, motor_neg);
    end

    // ---------------------------------------------------------------- door update
    assign room       = FT_POS - position_reg;
    assign move_open  = sim_en_reg && (dir_reg == dtpm_pkg::DIR_OPEN) && (position_reg < FT_POS);
    assign move_close = sim_en_reg && (dir_reg == dtpm_pkg::DIR_CLOSE) && (position_reg != '0);

    // open mark is full travel - margin and may go negative: compare pos + margin instead
    assign old_at_open  = ({1'b0, position_reg} + (POS_W+1)'(thr_reg)) >= (POS_W+1)'(FT_POS);
    assign old_at_close = position_reg <= POS_W'(thr_reg);
    assign new_at_open  = ({1'b0, position_next} + (POS_W+1)'(thr_reg)) >= (POS_W+1)'(FT_POS);
    assign new_at_close = position_next <= POS_W'(thr_reg);

    always_comb
    begin
        position_next = position_reg;
        state_next    = state_reg;
        if (move_open)
        begin
            if (quot >= PROD_W'(room))
                position_next = FT_POS;
            else
                position_next = position_reg + quot[POS_W-1:0];
            state_next = (position_next == FT_POS) ? dtpm_pkg::DOOR_OPEN
                                                   : dtpm_pkg::DOOR_OPENING;
        end
        else if (move_close)
        begin
            if (quot >= PROD_W'(position_reg))
                position_next = '0;
            else
                position_next = position_reg - quot[POS_W-1:0];
            state_next = (position_next == '0) ? dtpm_pkg::DOOR_CLOSED
                                               : dtpm_pkg::DOOR_CLOSING;
        end
        else if (sim_en_reg && (dir_reg == dtpm_pkg::DIR_STOP
                                || dir_reg == dtpm_pkg::DIR_BRAKE))
        begin
            // motor halted: settle on the hall thresholds
            if (old_at_open)
                state_next = dtpm_pkg::DOOR_OPEN;
            else if (old_at_close)
                state_next = dtpm_pkg::DOOR_CLOSED;
            else if (state_reg == dtpm_pkg::DOOR_OPENING
                     || state_reg == dtpm_pkg::DOOR_CLOSING)
                state_next = dtpm_pkg::DOOR_STOPPED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            state_reg    <= dtpm_pkg::DOOR_CLOSED;
        end
        else if (commit)
        begin
            position_reg <= position_next;
            state_reg    <= state_next;
        end
    end

    // ---------------------------------------------------------------- output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (commit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_pos_reg    <= position_next;
            out_state_reg  <= state_next;
            out_dir_reg    <= dir_reg;
            out_hopen_reg  <= !stuck_reg && new_at_open;
            out_hclose_reg <= !stuck_reg && new_at_close;
        end
    end

    assign out_valid   = out_valid_reg;
    assign door_pct    = out_pos_reg;
    assign door_status = out_state_reg;
    assign drive_dir   = out_dir_reg;
    assign hall_open   = out_hopen_reg;
    assign hall_close  = out_hclose_reg;

endmodule

`default_nettype wire

// ===== design/dtpm_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module dtpm_div #(
    parameter int DIVIDEND_W = dtpm_pkg::PROD_W,
    parameter int DIVISOR_W  = dtpm_pkg::TRAVEL_W
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output dtpm_pkg::dtpm_div_stat_t   stat,
    output logic      [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] dvd_reg, dvd_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  qbit;

    // dividend shifts out at the top while quotient bits shift in at the bottom
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[DIVIDEND_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        qbit     = (trial >= {1'b0, dsr_reg});
        cnt_next = cnt_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        if (start)
        begin
            cnt_next = CNT_W'(DIVIDEND_W);
            dvd_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            dvd_next = {dvd_reg[DIVIDEND_W-2:0], qbit};
            rem_next = qbit ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.last = (cnt_reg == CNT_W'(1));
    assign quotient  = dvd_reg;

endmodule

`default_nettype wire

// ===== design/dtpm_chk.sv =====
// Port-level checker for the door travel plant model, bound to the top level.
`default_nettype none

module dtpm_chk #(
    parameter int FULL_TRAVEL = dtpm_pkg::FULL_TRAVEL_DEF
) (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            cfg_valid,
    input wire logic                            cfg_ready,
    input wire logic [dtpm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input wire logic [dtpm_pkg::TRAVEL_W-1:0]   cfg_data,
    input wire logic                            in_valid,
    input wire logic                            in_stall,
    input wire logic [dtpm_pkg::ELAPSED_W-1:0]  elapsed_ms,
    input wire logic                            motor_pos,
    input wire logic                            motor_neg,
    input wire logic                            out_valid,
    input wire logic                            out_stall,
    input wire logic [dtpm_pkg::POS_W-1:0]      door_pct,
    input wire logic [2:0]                      door_status,
    input wire logic [1:0]                      drive_dir,
    input wire logic                            hall_open,
    input wire logic                            hall_close
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(door_pct)
                                   && $stable(door_status) && $stable(drive_dir))
        else $error("result word changed under stall");

    // one tick at a time: the divider is busy straight after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("tick accepted while busy");

    // no result can appear sooner than the divider allows
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> !out_valid)
        else $error("result word without division");

    // position never beyond full travel
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> door_pct <= dtpm_pkg::POS_W'(FULL_TRAVEL))
        else $error("door position out of range");

    // opening is never reported at the open end
    a_open_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && door_status == dtpm_pkg::DOOR_OPENING |->
            door_pct != dtpm_pkg::POS_W'(FULL_TRAVEL))
        else $error("opening reported at the open end");

endmodule

bind door_travel_plant_model_top dtpm_chk #(.FULL_TRAVEL(FULL_TRAVEL)) u_dtpm_chk (.*);

`default_nettype wire

// ===== verif/door_travel_plant_model_top_test.sv =====
// Self-checking testbench for the door travel plant model: directed and random tick words.
`timescale 1ns / 100ps

module door_travel_plant_model_top_test;

    localparam int FULL      = dtpm_pkg::FULL_TRAVEL_DEF;
    localparam int POS_W     = dtpm_pkg::POS_W;
    localparam int TRAVEL_W  = dtpm_pkg::TRAVEL_W;
    localparam int THR_W     = dtpm_pkg::THR_W;
    localparam int ELAPSED_W = dtpm_pkg::ELAPSED_W;

    // one result word as the door should report it
    typedef struct {
        logic [POS_W-1:0]       position;
        dtpm_pkg::door_status_t state;
        dtpm_pkg::dir_t         direction;
        logic                   hall_open;
        logic                   hall_close;
    } door_word_t;

    // ------------------------------------------------------------------
    // Clock, reset and the signals towards the block
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #6 clk = ~clk;

    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    dtpm_pkg::cfg_idx_t   cfg_index  = dtpm_pkg::REG_TRAVEL_TIME;
    logic [TRAVEL_W-1:0]  cfg_data   = '0;

    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic [ELAPSED_W-1:0] elapsed_ms = '0;
    logic                 motor_pos  = 1'b0;
    logic                 motor_neg  = 1'b0;

    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic [POS_W-1:0]     door_pct;
    logic [2:0]           door_status;
    logic [1:0]           drive_dir;
    logic                 hall_open;
    logic                 hall_close;

    door_travel_plant_model_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .elapsed_ms  (elapsed_ms),
        .motor_pos   (motor_pos),
        .motor_neg   (motor_neg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .door_pct    (door_pct),
        .door_status (door_status),
        .drive_dir   (drive_dir),
        .hall_open   (hall_open),
        .hall_close  (hall_close)
    );

    // ------------------------------------------------------------------
    // Door predictor: own copy of the registers and the door itself.
    // Starts from the reset defaults and follows every accepted write.
    // ------------------------------------------------------------------
    logic [TRAVEL_W-1:0] cfg_travel = dtpm_pkg::TRAVEL_RST;
    logic                cfg_sim    = 1'b1;
    logic                cfg_stuck  = 1'b0;
    logic [THR_W-1:0]    cfg_thr    = dtpm_pkg::THR_RST;

    int                     door_pos = 0;
    dtpm_pkg::door_status_t door_st  = dtpm_pkg::DOOR_CLOSED;

    door_word_t expected_words[$];
    int         mismatches = 0;
    bit         no_idle    = 1'b0;   // both sides run flat out while set

    // Moves the door by one tick and returns the word it should produce.
    function automatic door_word_t advance_door(logic [ELAPSED_W-1:0] elapsed,
                                                logic p, logic n);
        door_word_t     w;
        dtpm_pkg::dir_t drive;
        int unsigned    divisor;
        int unsigned    step;
        int             open_mark;
        int             close_mark;

        case ({p, n})
            2'b10:   drive = dtpm_pkg::DIR_OPEN;
            2'b01:   drive = dtpm_pkg::DIR_CLOSE;
            2'b11:   drive = dtpm_pkg::DIR_BRAKE;
            default: drive = dtpm_pkg::DIR_STOP;
        endcase

        // a travel time of zero behaves as one millisecond
        divisor    = (cfg_travel == '0) ? 1 : int'(cfg_travel);
        step       = (32'(elapsed) * FULL) / divisor;
        // signed marks: a wide margin can light both sensors together
        open_mark  = FULL - int'(cfg_thr);
        close_mark = int'(cfg_thr);

        if (cfg_sim)
        begin
            if (drive == dtpm_pkg::DIR_OPEN && door_pos < FULL)
            begin
                if (step >= FULL - door_pos)
                    door_pos = FULL;
                else
                    door_pos = door_pos + int'(step);
                door_st = (door_pos >= FULL) ? dtpm_pkg::DOOR_OPEN : dtpm_pkg::DOOR_OPENING;
            end
            else if (drive == dtpm_pkg::DIR_CLOSE && door_pos > 0)
            begin
                if (step >= door_pos)
                    door_pos = 0;
                else
                    door_pos = door_pos - int'(step);
                door_st = (door_pos == 0) ? dtpm_pkg::DOOR_CLOSED : dtpm_pkg::DOOR_CLOSING;
            end
            else if (drive == dtpm_pkg::DIR_STOP || drive == dtpm_pkg::DIR_BRAKE)
            begin
                // motor halted: settle from the hall margins
                if (door_pos >= open_mark)
                    door_st = dtpm_pkg::DOOR_OPEN;
                else if (door_pos <= close_mark)
                    door_st = dtpm_pkg::DOOR_CLOSED;
                else if (door_st == dtpm_pkg::DOOR_OPENING
                         || door_st == dtpm_pkg::DOOR_CLOSING)
                    door_st = dtpm_pkg::DOOR_STOPPED;
            end
        end

        w.position   = POS_W'(door_pos);
        w.state      = door_st;
        w.direction  = drive;
        w.hall_open  = !cfg_stuck && (door_pos >= open_mark);
        w.hall_close = !cfg_stuck && (door_pos <= close_mark);
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting and the result side
    // ------------------------------------------------------------------
    task automatic note_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_word();
        door_word_t w;
        if (expected_words.size() == 0)
        begin
            note_mismatch($sformatf("result word with none expected (pos %0d state %0d)",
                                    door_pct, door_status));
        end
        else
        begin
            w = expected_words.pop_front();
            if (door_pct !== w.position)
                note_mismatch($sformatf("door_pct %0d, want %0d", door_pct, w.position));
            if (door_status !== w.state)
                note_mismatch($sformatf("door_status %0d, want %0d", door_status, w.state));
            if (drive_dir !== w.direction)
                note_mismatch($sformatf("drive_dir %0d, want %0d", drive_dir, w.direction));
            if (hall_open !== w.hall_open)
                note_mismatch($sformatf("hall_open %0b, want %0b", hall_open, w.hall_open));
            if (hall_close !== w.hall_close)
                note_mismatch($sformatf("hall_close %0b, want %0b",
                                        hall_close, w.hall_close));
        end
    endtask

    // After each taken word the receiver draws a random hold, which may be zero.
    // Stall goes up straight away and only counts down once a word is
    // waiting, so every held word really sits on the output for a while.
    int rx_hold = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                check_word();
                rx_hold = no_idle ? 0 : $urandom_range(0, 7);
                out_stall <= (rx_hold != 0);
            end
            else if (out_stall)
            begin
                if (out_valid)
                    rx_hold = rx_hold - 1;
                out_stall <= (rx_hold > 0);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Sends one tick word. Valid is left high on return; the next call either
    // keeps it up (no gap) or drops it, so it never toggles within one step.
    task automatic send_tick(logic [ELAPSED_W-1:0] elapsed, logic p, logic n);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        elapsed_ms <= elapsed;
        motor_pos  <= p;
        motor_neg  <= n;
        do
            @(posedge clk);
        while (in_stall);
        expected_words.push_back(advance_door(elapsed, p, n));
    endtask

    // Drops valid and waits until every outstanding result word is in.
    task automatic settle(int extra);
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // Writes all four registers in index order, valid held across the burst.
    // The narrow registers get junk above their width, which must be ignored.
    task automatic apply_config(logic [TRAVEL_W-1:0] travel, logic sim, logic stuck,
                                logic [THR_W-1:0] thr);
        dtpm_pkg::cfg_idx_t  idx;
        logic [TRAVEL_W-1:0] junk;
        junk = TRAVEL_W'($urandom);
        idx  = dtpm_pkg::REG_TRAVEL_TIME;
        cfg_valid <= 1'b1;
        repeat (4)
        begin
            cfg_index <= idx;
            case (idx)
                dtpm_pkg::REG_TRAVEL_TIME: cfg_data <= travel;
                dtpm_pkg::REG_SIM_ENABLE:  cfg_data <= {junk[TRAVEL_W-1:1], sim};
                dtpm_pkg::REG_STUCK_MODE:  cfg_data <= {junk[TRAVEL_W-1:1], stuck};
                default:                   cfg_data <= {junk[TRAVEL_W-1:THR_W], thr};
            endcase
            do
                @(posedge clk);
            while (!cfg_ready);
            idx = idx.next();
        end
        cfg_valid  <= 1'b0;
        cfg_travel = travel;
        cfg_sim    = sim;
        cfg_stuck  = stuck;
        cfg_thr    = thr;
    endtask

    // Elapsed times mostly scaled to give small, useful steps for the
    // current travel time; the rest are the extremes and raw random values.
    function automatic logic [ELAPSED_W-1:0] pick_elapsed();
        longint unsigned span;
        longint unsigned e;
        span = (cfg_travel == '0) ? 1 : cfg_travel;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return ELAPSED_W'($urandom);
            default:
            begin
                e = ($urandom_range(0, 25) * span + $urandom_range(0, span - 1)) / FULL;
                return (e > 16'hFFFF) ? 16'hFFFF : ELAPSED_W'(e);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset defaults in force: 10 s travel, margin 5.
    task automatic test_reset_defaults();
        send_tick(16'd0, 1'b0, 1'b0);       // stopped at the closed end
        send_tick(16'd150, 1'b1, 1'b0);     // one percent open
        send_tick(16'hFFFF, 1'b1, 1'b1);    // brake inside the closed margin
        send_tick(16'hFFFF, 1'b0, 1'b1);    // long close, saturates at 0
        send_tick(16'd1000, 1'b0, 1'b1);    // closing at 0 changes nothing
    endtask

    task automatic test_travel_extremes();
        settle(4);
        apply_config(20'd1, 1'b1, 1'b0, 6'd5);
        send_tick(16'hFFFF, 1'b1, 1'b0);    // huge step, saturates open
        send_tick(16'd0, 1'b1, 1'b0);       // opening at the open end
        send_tick(16'd0, 1'b0, 1'b0);
        settle(4);
        apply_config(20'd0, 1'b1, 1'b0, 6'd5);    // zero travel acts as 1 ms
        send_tick(16'd1, 1'b0, 1'b1);
        settle(4);
        apply_config(20'hFFFFF, 1'b1, 1'b0, 6'd5); // slowest door
        send_tick(16'hFFFF, 1'b1, 1'b0);
        send_tick(16'hFFFF, 1'b1, 1'b0);
        send_tick(16'd7, 1'b0, 1'b0);       // halted mid travel
        send_tick(16'd7, 1'b1, 1'b1);
        send_tick(16'hFFFF, 1'b0, 1'b1);
        send_tick(16'd0, 1'b0, 1'b0);
    endtask

    task automatic test_hall_margins();
        settle(4);
        apply_config(20'd100, 1'b1, 1'b0, 6'd50);
        send_tick(16'd44, 1'b1, 1'b0);
        settle(4);
        apply_config(20'd100, 1'b1, 1'b0, 6'd63);  // beyond range: both sensors
        send_tick(16'd0, 1'b0, 1'b0);
        settle(4);
        apply_config(20'd100, 1'b1, 1'b0, 6'd0);
        send_tick(16'hFFFF, 1'b1, 1'b0);
        send_tick(16'd0, 1'b1, 1'b1);
    endtask

    task automatic test_stuck_and_freeze();
        settle(4);
        apply_config(20'd100, 1'b1, 1'b1, 6'd5);
        send_tick(16'd50, 1'b0, 1'b1);
        settle(4);
        apply_config(20'd100, 1'b0, 1'b0, 6'd5);   // simulation off: door frozen
        send_tick(16'hFFFF, 1'b1, 1'b0);
        send_tick(16'hFFFF, 1'b0, 1'b1);
        send_tick(16'd0, 1'b0, 1'b0);
        send_tick(16'd3, 1'b1, 1'b1);
    endtask

    // Runs of one drive direction with random timing, some noise words, the
    // odd pause until the pipeline is empty, and flat-out stretches.
    task automatic run_random_phase(int n_items);
        int   sent;
        int   run_left;
        int   pick;
        logic p_line;
        logic n_line;
        sent     = 0;
        run_left = 0;
        p_line   = 1'b0;
        n_line   = 1'b0;
        while (sent < n_items)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(1, 8);
                no_idle  = ($urandom_range(0, 5) == 0);
                pick     = $urandom_range(0, 99);
                if (pick < 35)
                    {p_line, n_line} = 2'b10;
                else if (pick < 70)
                    {p_line, n_line} = 2'b01;
                else if (pick < 85)
                    {p_line, n_line} = 2'b00;
                else
                    {p_line, n_line} = 2'b11;
            end
            if ($urandom_range(0, 9) == 0)
                send_tick(ELAPSED_W'($urandom), 1'($urandom), 1'($urandom));
            else
                send_tick(pick_elapsed(), p_line, n_line);
            run_left--;
            sent++;
            if ($urandom_range(0, 59) == 0)
                settle(0);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_configs();
        logic [TRAVEL_W-1:0] travel;
        logic [THR_W-1:0]    thr;
        logic                stuck;
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       travel = dtpm_pkg::TRAVEL_RST;
                1:       travel = TRAVEL_W'($urandom_range(1, 400));
                2:       travel = '0;
                3:       travel = '1;
                4:       travel = TRAVEL_W'(1);
                default: travel = TRAVEL_W'($urandom);
            endcase
            case (ph)
                0:       thr = dtpm_pkg::THR_RST;
                1:       thr = '0;
                2:       thr = THR_W'(50);
                3:       thr = '1;
                default: thr = THR_W'($urandom);
            endcase
            stuck = ($urandom_range(0, 3) == 0);
            settle(4);
            // phase 5 freezes the door; the rest let it move
            apply_config(travel, ph != 5, stuck, thr);
            run_random_phase((ph == 5) ? 60 : 180);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_travel_extremes();
        test_hall_margins();
        test_stuck_and_freeze();
        test_random_configs();

        settle(40);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
